FILE: design/lbct_pkg.sv
// shared constants and codes for the block cache tag engine
// no dependencies; imported by lru_block_cache_tags and its testbench
package lbct_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = ADDR_W + 1;

  localparam int CMD_W   = 2;
  localparam int DISK_W  = 5;
  localparam int BLOCK_W = 17;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 32;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int EIU_W   = 7;
  localparam int CIDX_W  = 2;
  localparam int ENTRY_W = DISK_W + BLOCK_W + STAMP_W;

  localparam logic [DISK_W-1:0]  DISK_LIMIT  = DISK_W'(16);
  localparam logic [BLOCK_W-1:0] BLOCK_LIMIT = BLOCK_W'(65536);
  localparam logic [EIU_W-1:0]   EIU_RESET   = EIU_W'(64);

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 3'd1;
  localparam logic [STAT_W-1:0] ST_OFF   = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd4;

  localparam logic [CIDX_W-1:0] REG_CACHE_ON = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ENTRIES  = 2'd1;

  typedef struct packed {
    logic [DISK_W-1:0]  disk;
    logic [BLOCK_W-1:0] block;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

FILE: design/lbct_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lbct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lru_block_cache_tags.sv
// tag and lru engine of a fully associative block cache
// depends on lbct_pkg and lbct_ram (key and stamp store)
//
//   channel | ports                                        | direction
//   in      | in_valid in_stall in_cmd in_disk/block_number | item in
//   out     | out_valid out_stall out_status/slot/evicted.. | result out
//   cfg     | cfg_we cfg_index cfg_wdata                   | register write
//
// lookup, update and in-range insert with the cache on scan the active slots
// through the single read port of the tag ram, one entry a cycle; other items
// skip the scan. no new item is taken until the last result is loaded out.
// reset is synchronous, active low; it clears valid bits, counters and clock,
// and the input is held off while it is asserted.
// a stalled result waits in the output register while the next item is taken.
module lru_block_cache_tags (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lbct_pkg::CMD_W-1:0]   in_cmd,
  input  logic [lbct_pkg::DISK_W-1:0]  in_disk_number,
  input  logic [lbct_pkg::BLOCK_W-1:0] in_block_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lbct_pkg::STAT_W-1:0]  out_status,
  output logic [lbct_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_evicted,
  output logic [lbct_pkg::COUNT_W-1:0] out_query_total,
  output logic [lbct_pkg::COUNT_W-1:0] out_hit_total,
  input  logic                         cfg_we,
  input  logic [lbct_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lbct_pkg::EIU_W-1:0]   cfg_wdata
);
  import lbct_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  localparam int CMP_W = (CNT_W > EIU_W) ? CNT_W : EIU_W;
  localparam logic [CMP_W-1:0] N_MIN = CMP_W'(2);
  localparam logic [CMP_W-1:0] N_MAX = CMP_W'(MAX_ENTRIES);

  logic [1:0]             state_r, state_nxt;
  logic                   cache_on_r;
  logic [EIU_W-1:0]       eiu_r;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [STAMP_W-1:0]     tick_r, tick_nxt;
  logic [COUNT_W-1:0]     query_r, query_nxt;
  logic [COUNT_W-1:0]     hit_r, hit_nxt;

  // scan control
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       pidx_r, pidx_nxt;
  logic                   pv_r, pv_nxt;

  // item being worked on
  logic [CMD_W-1:0]       cmd_r;
  logic [DISK_W-1:0]      disk_r;
  logic [BLOCK_W-1:0]     block_r;

  // insert search state
  logic                   dup_r, dup_nxt;
  logic                   found_r, found_nxt;
  logic                   free_r, free_nxt;
  logic [ADDR_W-1:0]      free_idx_r, free_idx_nxt;
  logic [STAMP_W-1:0]     min_r, min_nxt;
  logic [ADDR_W-1:0]      min_idx_r, min_idx_nxt;

  // pending result
  logic [STAT_W-1:0]      res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]      res_slot_r, res_slot_nxt;
  logic                   res_evict_r, res_evict_nxt;

  logic                   out_valid_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic                   out_evicted_r;
  logic [COUNT_W-1:0]     out_query_r;
  logic [COUNT_W-1:0]     out_hit_r;

  logic                   accept;
  logic                   out_load;
  logic [CMP_W-1:0]       eiu_ext;
  logic [CNT_W-1:0]       n_act;
  logic                   cache_clear;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr;
  entry_t                 ram_wdata, ram_rdata;

  logic                   ent_valid, ent_match, last;
  logic [ADDR_W-1:0]      cur;
  logic                   range_bad;

  lbct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // active slot count, saturated into [2, MAX_ENTRIES]
  always_comb begin
    eiu_ext = CMP_W'(eiu_r);
    priority if (eiu_ext < N_MIN) begin
      n_act = CNT_W'(N_MIN);
    end else if (eiu_ext > N_MAX) begin
      n_act = CNT_W'(N_MAX);
    end else begin
      n_act = CNT_W'(eiu_ext);
    end
  end

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state_r != S_IDLE) || !rst_n;
  assign out_load    = (state_r == S_WAIT) && (!out_valid_r || !out_stall);
  assign cache_clear = cfg_we && (cfg_index == REG_CACHE_ON) && cfg_wdata[0] && !cache_on_r;
  assign range_bad   = (in_disk_number > DISK_LIMIT) || (in_block_number > BLOCK_LIMIT);

  assign cur       = pidx_r[ADDR_W-1:0];
  assign ent_valid = valid_r[cur];
  assign ent_match = ent_valid && (ram_rdata.disk == disk_r) && (ram_rdata.block == block_r);
  assign last      = (pidx_r == n_act - CNT_W'(1));

  always_comb begin
    logic              dup_now, free_now;
    logic [ADDR_W-1:0] free_idx_now, min_idx_now, pick;
    logic [STAMP_W-1:0] min_now;

    state_nxt      = state_r;
    valid_nxt      = valid_r;
    tick_nxt       = tick_r;
    query_nxt      = query_r;
    hit_nxt        = hit_r;
    idx_nxt        = idx_r;
    pidx_nxt       = pidx_r;
    pv_nxt         = 1'b0;
    dup_nxt        = dup_r;
    found_nxt      = found_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    min_nxt        = min_r;
    min_idx_nxt    = min_idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_evict_nxt  = res_evict_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = cur;
    ram_wdata      = '{disk: ram_rdata.disk, block: ram_rdata.block, stamp: tick_r};

    // current entry folded into the insert search
    dup_now      = dup_r || ent_match;
    free_now     = free_r || !ent_valid;
    free_idx_now = free_r ? free_idx_r : cur;
    if ((pidx_r == '0) || (ram_rdata.stamp < min_r)) begin
      min_now     = ram_rdata.stamp;
      min_idx_now = cur;
    end else begin
      min_now     = min_r;
      min_idx_now = min_idx_r;
    end
    pick = free_now ? free_idx_now : min_idx_now;

    if (cache_clear) begin
      valid_nxt = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt        = '0;
          dup_nxt        = 1'b0;
          found_nxt      = 1'b0;
          free_nxt       = 1'b0;
          res_status_nxt = ST_OK;
          res_slot_nxt   = '0;
          res_evict_nxt  = 1'b0;
          state_nxt      = S_WAIT;
          unique case (in_cmd)
            CMD_LOOKUP: begin
              tick_nxt  = tick_r + STAMP_W'(1);
              query_nxt = query_r + COUNT_W'(1);
              if (!cache_on_r) begin
                res_status_nxt = ST_OFF;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_UPDATE: begin
              tick_nxt = tick_r + STAMP_W'(1);
              if (!cache_on_r) begin
                res_status_nxt = ST_OFF;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_INSERT: begin
              priority if (range_bad) begin
                res_status_nxt = ST_RANGE;
              end else if (!cache_on_r) begin
                res_status_nxt = ST_OFF;
              end else begin
                tick_nxt  = tick_r + STAMP_W'(1);
                state_nxt = S_SCAN;
              end
            end
            CMD_NOP: begin
              res_status_nxt = ST_OK;
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx_r < n_act) begin
          ram_re   = 1'b1;
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + CNT_W'(1);
        end
        if (pv_r) begin
          unique case (cmd_r)
            CMD_LOOKUP: begin
              if (ent_match) begin
                ram_we         = 1'b1;
                hit_nxt        = hit_r + COUNT_W'(1);
                res_status_nxt = ST_OK;
                res_slot_nxt   = cur;
                state_nxt      = S_WAIT;
              end else if (last) begin
                res_status_nxt = ST_MISS;
                state_nxt      = S_WAIT;
              end
            end
            CMD_UPDATE: begin
              // every match is restamped, the first one is reported
              if (ent_match) begin
                ram_we    = 1'b1;
                found_nxt = 1'b1;
                if (!found_r) begin
                  res_slot_nxt = cur;
                end
              end
              if (last) begin
                res_status_nxt = (found_r || ent_match) ? ST_OK : ST_MISS;
                state_nxt      = S_WAIT;
              end
            end
            default: begin
              dup_nxt      = dup_now;
              free_nxt     = free_now;
              free_idx_nxt = free_idx_now;
              min_nxt      = min_now;
              min_idx_nxt  = min_idx_now;
              if (last) begin
                state_nxt = S_WAIT;
                if (dup_now) begin
                  res_status_nxt = ST_DUP;
                end else begin
                  ram_we         = 1'b1;
                  ram_waddr      = pick;
                  ram_wdata      = '{disk: disk_r, block: block_r, stamp: tick_r};
                  valid_nxt[pick] = 1'b1;
                  res_status_nxt = ST_OK;
                  res_slot_nxt   = pick;
                  res_evict_nxt  = !free_now;
                end
              end
            end
          endcase
        end
      end
      S_WAIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cache_on_r  <= 1'b0;
      eiu_r       <= EIU_RESET;
      valid_r     <= '0;
      tick_r      <= '0;
      query_r     <= '0;
      hit_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      tick_r  <= tick_nxt;
      query_r <= query_nxt;
      hit_r   <= hit_nxt;
      pv_r    <= pv_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CACHE_ON: cache_on_r <= cfg_wdata[0];
          REG_ENTRIES:  eiu_r      <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    dup_r        <= dup_nxt;
    found_r      <= found_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    min_r        <= min_nxt;
    min_idx_r    <= min_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_evict_r  <= res_evict_nxt;
    if (accept) begin
      cmd_r   <= in_cmd;
      disk_r  <= in_disk_number;
      block_r <= in_block_number;
    end
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_slot_r    <= SLOT_W'(res_slot_r);
      out_evicted_r <= res_evict_r;
      out_query_r   <= query_r;
      out_hit_r     <= hit_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_evicted     = out_evicted_r;
  assign out_query_total = out_query_r;
  assign out_hit_total   = out_hit_r;

endmodule

FILE: sim/tb_lru_block_cache_tags.sv
// testbench for lru_block_cache_tags: directed and random lookups, updates and inserts
// checked item by item against an in-bench model of the tag store and lru stamps
// depends on lbct_pkg and the lru_block_cache_tags rtl
module tb_lru_block_cache_tags;
  timeunit 1ns;
  timeprecision 1ps;
  import lbct_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 200;
  localparam int POOL_MAX        = 128;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int END_WAIT        = 2 * MAX_ENTRIES + 16;

  // indexes past the two registers, written only to show they are ignored
  localparam logic [CIDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [COUNT_W-1:0] queries;
    logic [COUNT_W-1:0] hits;
  } cache_reply_t;

  class cache_tag_scoreboard;
    logic               on;
    logic [EIU_W-1:0]   eiu;
    logic               valid_bits [MAX_ENTRIES];
    logic [DISK_W-1:0]  disks [MAX_ENTRIES];
    logic [BLOCK_W-1:0] blocks [MAX_ENTRIES];
    logic [STAMP_W-1:0] stamps [MAX_ENTRIES];
    logic [STAMP_W-1:0] ticks;
    logic [COUNT_W-1:0] queries;
    logic [COUNT_W-1:0] hits;
    cache_reply_t       awaited [$];
    int                 errors;
    int                 evictions;
    int                 items;

    function new();
      on = 1'b0;
      eiu = EIU_RESET;
      ticks = '0;
      queries = '0;
      hits = '0;
      errors = 0;
      evictions = 0;
      items = 0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid_bits[i] = 1'b0;
        disks[i] = '0;
        blocks[i] = '0;
        stamps[i] = '0;
      end
    endfunction

    function int active_slots();
      if (eiu < 2) return 2;
      if (eiu > MAX_ENTRIES) return MAX_ENTRIES;
      return int'(eiu);
    endfunction

    function bit slot_holds(int i, logic [DISK_W-1:0] d, logic [BLOCK_W-1:0] b);
      return valid_bits[i] && disks[i] == d && blocks[i] == b;
    endfunction

    function int find_key(logic [DISK_W-1:0] d, logic [BLOCK_W-1:0] b);
      for (int i = 0; i < active_slots(); i++)
        if (slot_holds(i, d, b)) return i;
      return -1;
    endfunction

    function void write_register(logic [CIDX_W-1:0] idx, logic [EIU_W-1:0] data);
      case (idx)
        REG_CACHE_ON: begin
          // only an off-to-on transition wipes the entries
          if (data[0] && !on)
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              valid_bits[i] = 1'b0;
              stamps[i] = '0;
            end
          on = data[0];
        end
        REG_ENTRIES: eiu = data;
        default: ;
      endcase
    endfunction

    function void note_access(logic [CMD_W-1:0] cmd, logic [DISK_W-1:0] d,
                              logic [BLOCK_W-1:0] b);
      cache_reply_t r;
      int n;
      int k;
      int pick;
      logic [STAMP_W-1:0] least;
      bit found;
      r.status = ST_OK;
      r.slot = '0;
      r.evicted = 1'b0;
      n = active_slots();
      items++;
      case (cmd)
        CMD_LOOKUP: begin
          ticks++;
          queries++;
          if (!on) r.status = ST_OFF;
          else begin
            k = find_key(d, b);
            if (k < 0) r.status = ST_MISS;
            else begin
              hits++;
              stamps[k] = ticks;
              r.slot = SLOT_W'(k);
            end
          end
        end
        CMD_UPDATE: begin
          ticks++;
          if (!on) r.status = ST_OFF;
          else begin
            found = 1'b0;
            // every copy of the key is restamped, the first is reported
            for (int i = 0; i < n; i++)
              if (slot_holds(i, d, b)) begin
                stamps[i] = ticks;
                if (!found) r.slot = SLOT_W'(i);
                found = 1'b1;
              end
            if (!found) r.status = ST_MISS;
          end
        end
        CMD_INSERT: begin
          if (d > DISK_LIMIT || b > BLOCK_LIMIT) r.status = ST_RANGE;
          else if (!on) r.status = ST_OFF;
          else begin
            ticks++;
            if (find_key(d, b) >= 0) r.status = ST_DUP;
            else begin
              pick = -1;
              for (int i = 0; i < n && pick < 0; i++)
                if (!valid_bits[i]) pick = i;
              if (pick < 0) begin
                pick = 0;
                least = stamps[0];
                for (int i = 1; i < n; i++)
                  if (stamps[i] < least) begin
                    least = stamps[i];
                    pick = i;
                  end
                r.evicted = 1'b1;
                evictions++;
              end
              valid_bits[pick] = 1'b1;
              disks[pick] = d;
              blocks[pick] = b;
              stamps[pick] = ticks;
              r.slot = SLOT_W'(pick);
            end
          end
        end
        default: ;
      endcase
      r.queries = queries;
      r.hits = hits;
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_reply(cache_reply_t got);
      cache_reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: reply with none awaited, expected nothing, got status %0d slot %0d",
                 $time, got.status, got.slot);
        return;
      end
      want = awaited.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
      compare_field("query_total", want.queries, got.queries);
      compare_field("hit_total", want.hits, got.hits);
    endfunction
  endclass

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [DISK_W-1:0]   in_disk_number = '0;
  logic [BLOCK_W-1:0]  in_block_number = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_evicted;
  logic [COUNT_W-1:0]  out_query_total;
  logic [COUNT_W-1:0]  out_hit_total;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [EIU_W-1:0]    cfg_wdata = '0;

  cache_tag_scoreboard board = new();

  logic [DISK_W-1:0]   pool_disk [POOL_MAX];
  logic [BLOCK_W-1:0]  pool_block [POOL_MAX];
  int                  pool_len = 1;
  int                  send_run = 0;
  int                  take_run = 0;
  int                  reg_writes = 0;
  int unsigned         cycle_count = 0;

  lru_block_cache_tags DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d replies still awaited", $time, board.awaited.size());
      $display("lru_block_cache_tags regression: fail");
      $finish;
    end
  end

  // idle draw with occasional stretches of back-to-back items
  function automatic int pick_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) run_left = $urandom_range(8, 40);
    return $urandom_range(0, 14);
  endfunction

  task automatic offer(input logic [CMD_W-1:0] c, input logic [DISK_W-1:0] d,
                       input logic [BLOCK_W-1:0] b);
    int gap;
    gap = pick_gap(send_run);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_disk_number <= d;
    in_block_number <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    board.note_access(c, d, b);
  endtask

  // registers change only with the block drained
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [EIU_W-1:0] data);
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_register(idx, data);
    reg_writes++;
  endtask

  task automatic refill_pool(input int n);
    int r;
    pool_len = n + $urandom_range(0, n);
    if (pool_len > POOL_MAX) pool_len = POOL_MAX;
    for (int i = 0; i < pool_len; i++) begin
      r = $urandom_range(0, 9);
      pool_disk[i] = (r == 0) ? DISK_LIMIT : (r == 1) ? '0 : DISK_W'($urandom_range(0, 16));
      r = $urandom_range(0, 9);
      pool_block[i] = (r == 0) ? BLOCK_LIMIT :
                      (r == 1) ? '0 : BLOCK_W'($urandom_range(0, 65536));
    end
  endtask

  // mostly pool keys so that hits, duplicates and evictions happen; the rest is noise
  task automatic random_item();
    int r;
    int k;
    logic [CMD_W-1:0] c;
    logic [DISK_W-1:0] d;
    logic [BLOCK_W-1:0] b;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, pool_len - 1);
    d = pool_disk[k];
    b = pool_block[k];
    if (r < 35) c = CMD_INSERT;
    else if (r < 65) c = CMD_LOOKUP;
    else if (r < 80) c = CMD_UPDATE;
    else begin
      d = DISK_W'($urandom);
      b = BLOCK_W'($urandom);
      if (r < 86) c = CMD_LOOKUP;
      else if (r < 90) c = CMD_UPDATE;
      else if (r < 96) c = CMD_INSERT;
      else c = CMD_NOP;
    end
    offer(c, d, b);
  endtask

  initial begin : reply_side
    int hold;
    int taken;
    taken = 0;
    forever begin
      // one long hold-off lets the block back up into its input
      hold = (taken == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : pick_gap(take_run);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      taken++;
    end
  end

  always @(posedge clk) begin : reply_check
    cache_reply_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.status = out_status;
      seen.slot = out_slot;
      seen.evicted = out_evicted;
      seen.queries = out_query_total;
      seen.hits = out_hit_total;
      board.check_reply(seen);
    end
  end

  initial begin : stimulus
    logic [EIU_W-1:0] slots;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // cache off after reset; range check wins over the off check
    offer(CMD_LOOKUP, '0, '0);
    offer(CMD_UPDATE, DISK_LIMIT, BLOCK_LIMIT);
    offer(CMD_INSERT, 5'd17, '0);
    offer(CMD_INSERT, 5'd5, 17'd5);
    offer(CMD_NOP, '1, '1);

    write_reg(REG_ENTRIES, 7'd2);
    write_reg(REG_CACHE_ON, 7'h01);
    offer(CMD_INSERT, '0, '0);
    offer(CMD_INSERT, DISK_LIMIT, BLOCK_LIMIT);
    offer(CMD_INSERT, '0, '0);
    offer(CMD_LOOKUP, '0, '0);
    offer(CMD_INSERT, 5'd3, 17'd7);
    offer(CMD_LOOKUP, DISK_LIMIT, BLOCK_LIMIT);
    offer(CMD_UPDATE, 5'd3, 17'd7);
    offer(CMD_UPDATE, 5'd9, 17'd9);
    offer(CMD_INSERT, '0, 17'd65537);
    offer(CMD_INSERT, '1, '1);
    offer(CMD_LOOKUP, '1, '1);

    // shrinking the search window lets one key land in two slots
    write_reg(REG_ENTRIES, 7'd8);
    offer(CMD_INSERT, 5'd4, 17'd4);
    write_reg(REG_ENTRIES, 7'd2);
    offer(CMD_INSERT, 5'd4, 17'd4);
    write_reg(REG_ENTRIES, 7'd8);
    offer(CMD_UPDATE, 5'd4, 17'd4);
    offer(CMD_LOOKUP, 5'd4, 17'd4);
    offer(CMD_NOP, '0, '0);

    // off then on again wipes the entries
    write_reg(REG_CACHE_ON, 7'h7E);
    write_reg(REG_CACHE_ON, 7'h01);
    offer(CMD_LOOKUP, 5'd4, 17'd4);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: slots = 7'd64;
        1: slots = 7'd2;
        2: slots = 7'd127;
        3: slots = 7'd0;
        4: slots = 7'd1;
        5: slots = 7'd17;
        6: slots = 7'd63;
        default: slots = EIU_W'($urandom_range(3, 64));
      endcase
      write_reg(REG_ENTRIES, slots);
      case (p)
        0: write_reg(REG_CACHE_ON, 7'h7F);
        1: begin
          write_reg(REG_SPARE_LO, 7'h55);
          write_reg(REG_SPARE_HI, 7'h2A);
        end
        3: write_reg(REG_CACHE_ON, 7'h00);
        4: write_reg(REG_CACHE_ON, 7'h7F);
        5: ;
        6: write_reg(REG_CACHE_ON, 7'h03);
        default: begin
          write_reg(REG_CACHE_ON, 7'h7E);
          write_reg(REG_CACHE_ON, 7'h01);
        end
      endcase
      refill_pool(board.active_slots());
      repeat (PHASE_ITEMS) random_item();
    end

    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("ran %0d items through %0d register writes with random idling on both sides",
             board.items, reg_writes);
    $display("saw %0d lookup hits and %0d evictions; %0d mismatches",
             board.hits, board.evictions, board.errors);
    if (board.errors == 0 && board.awaited.size() == 0)
      $display("lru_block_cache_tags regression: pass");
    else
      $display("lru_block_cache_tags regression: fail");
    $finish;
  end

endmodule

FILE: lru_block_cache_tags.f
design/lbct_pkg.sv
design/lbct_ram.sv
design/lru_block_cache_tags.sv
sim/tb_lru_block_cache_tags.sv
